FILE: hw/rtl/sfd_pkg.sv
// sfd_pkg: shared types, constants and fixed-point helpers for the stereo feedback delay
// depends on nothing; imported by stereo_feedback_delay
`default_nettype none

package sfd_pkg;

    // ring geometry and sample widths
    localparam int RING_DEPTH  = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int IO_BITS     = 16;
    localparam int GAIN_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // fixed point: Q1.15 gains, 32768 is unity
    localparam int FRAC_BITS  = 15;
    localparam int UNITY      = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // accumulator wide enough for two sample-by-gain products
    localparam int WIDE_BITS = (SAMPLE_BITS > IO_BITS) ? SAMPLE_BITS : IO_BITS;
    localparam int ACC_W     = WIDE_BITS + GAIN_W + 3;

    // reset values
    localparam int DELAY_RESET = 20000;
    localparam int WET_RESET   = 13107;

    localparam logic [PTR_W-1:0] WP_RESET  = PTR_W'(DELAY_RESET % RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);

    // saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] IO_MAX_W =
        ACC_W'((64'sd1 <<< (IO_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] IO_MIN_W = -IO_MAX_W - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] RING_MAX_W =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] RING_MIN_W = -RING_MAX_W - ACC_W'(1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_TIME     = 3'd0,
        REG_FEEDBACK_GAIN  = 3'd1,
        REG_WET_MIX        = 3'd2,
        REG_INPUT_ROUTING  = 3'd3,
        REG_OUTPUT_ROUTING = 3'd4
    } cfg_reg_t;

    // input routing codes
    typedef enum logic [1:0] {
        IN_LEFT_BOTH  = 2'd0,
        IN_RIGHT_BOTH = 2'd1,
        IN_STEREO     = 2'd2,
        IN_SILENCE    = 2'd3
    } in_route_t;

    // output routing codes
    typedef enum logic [1:0] {
        OUT_LEFT_ONLY  = 2'd0,
        OUT_RIGHT_ONLY = 2'd1,
        OUT_BOTH       = 2'd2,
        OUT_NONE       = 2'd3
    } out_route_t;

    // round half up: add half an lsb, then floor shift
    function automatic logic signed [ACC_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(ROUND_HALF);
        return t >>> FRAC_BITS;
    endfunction

    // clamp to the output sample range
    function automatic logic signed [IO_BITS-1:0] sat_io(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > IO_MAX_W) ? IO_MAX_W : ((v < IO_MIN_W) ? IO_MIN_W : v);
        return c[IO_BITS-1:0];
    endfunction

    // clamp to the ring sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_ring(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        c = (v > RING_MAX_W) ? RING_MAX_W : ((v < RING_MIN_W) ? RING_MIN_W : v);
        return c[SAMPLE_BITS-1:0];
    endfunction

    // pointer advance modulo ring depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stereo_feedback_delay.sv
// stereo_feedback_delay: feedback delay echo over two circular sample rings
// depends on sfd_pkg for widths, register codes and fixed-point helpers
//
// Usage:
//   input channel  : in_valid / in_stall, one stereo pair (in_left, in_right) per transfer
//   output channel : out_valid / out_stall, one mixed pair with left_valid / right_valid
//   config channel : cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//                    always high, writes are meant to land only while the block is idle
// Path: the ring read register and the first stage load at the input transfer, and the
//   output register loads from the first stage. Throughput: one pair per cycle while
//   in_stall is low; the single ring read port and single ring write port each serve one
//   access per item.
// When a write at delay offset one lands in the same cycle as the next item's ring read,
//   that written value is forwarded around the memory.
// Reset: registers take their reset values, then a clearing pass zeroes both rings,
//   one entry per cycle, over all RING_DEPTH (65536) entries. in_stall is high during the
//   pass; configuration writes are taken as usual.
// Stall: when out_stall holds a result, the item behind it waits in the first stage
//   and in_stall rises only once both stages are full.
`default_nettype none

module stereo_feedback_delay (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    output logic                                            in_stall,
    input  wire logic signed [sfd_pkg::IO_BITS-1:0]         in_left,
    input  wire logic signed [sfd_pkg::IO_BITS-1:0]         in_right,
    output logic                                            out_valid,
    input  wire logic                                       out_stall,
    output logic signed [sfd_pkg::IO_BITS-1:0]              out_left,
    output logic signed [sfd_pkg::IO_BITS-1:0]              out_right,
    output logic                                            left_valid,
    output logic                                            right_valid,
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import sfd_pkg::*;

    // sample rings
    logic signed [SAMPLE_BITS-1:0] ring_left  [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] ring_right [RING_DEPTH];

    // configuration and pointers
    logic [GAIN_W-1:0] fb_gain_reg, fb_gain_next;
    logic [GAIN_W-1:0] wet_reg, wet_next;
    in_route_t         in_route_reg, in_route_next;
    out_route_t        out_route_reg, out_route_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;

    // clearing pass
    logic              clr_busy_reg, clr_busy_next;
    logic [PTR_W-1:0]  clr_addr_reg, clr_addr_next;

    // first stage: routed input, ring read data, forwarded value
    logic                          s1_valid_reg, s1_valid_next;
    logic signed [IO_BITS-1:0]     s1_x_left_reg, s1_x_right_reg;
    logic [PTR_W-1:0]              s1_wp_reg;
    logic signed [SAMPLE_BITS-1:0] rd_left_reg, rd_right_reg;
    logic                          fwd_reg, fwd_next;
    logic signed [SAMPLE_BITS-1:0] fwd_left_reg, fwd_right_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [IO_BITS-1:0] out_left_reg, out_right_reg;
    logic                      left_valid_reg, right_valid_reg;

    logic cfg_we;
    logic accept;
    logic s1_advance;
    logic signed [IO_BITS-1:0]     x_left, x_right;
    logic signed [SAMPLE_BITS-1:0] d_left, d_right;
    logic signed [GAIN_W:0]        wet_s, dry_s, fb_s;
    logic signed [ACC_W-1:0]       mix_left, mix_right, fbp_left, fbp_right;
    logic signed [ACC_W-1:0]       wr_acc_left, wr_acc_right;
    logic signed [SAMPLE_BITS-1:0] wr_left, wr_right;
    logic signed [IO_BITS-1:0]     y_left, y_right;
    logic                          lv, rv;
    logic                          ram_we;
    logic [PTR_W-1:0]              ram_addr;
    logic signed [SAMPLE_BITS-1:0] ram_wd_left, ram_wd_right;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = clr_busy_reg || (s1_valid_reg && !s1_advance);
    assign accept     = in_valid && !in_stall;

    // input routing
    always_comb
    begin
        case (in_route_reg)
            IN_LEFT_BOTH:
            begin
                x_left  = in_left;
                x_right = in_left;
            end
            IN_RIGHT_BOTH:
            begin
                x_left  = in_right;
                x_right = in_right;
            end
            IN_STEREO:
            begin
                x_left  = in_left;
                x_right = in_right;
            end
            default:
            begin
                x_left  = '0;
                x_right = '0;
            end
        endcase
    end

    // configuration writes and pointer advance
    always_comb
    begin
        fb_gain_next   = fb_gain_reg;
        wet_next       = wet_reg;
        in_route_next  = in_route_reg;
        out_route_next = out_route_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        if (accept)
        begin
            wp_next = ptr_inc(wp_reg);
            rp_next = ptr_inc(rp_reg);
        end
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DELAY_TIME:
                begin
                    if (32'(cfg_data) < 32'(RING_DEPTH))
                    begin
                        wp_next = PTR_W'(cfg_data);
                        rp_next = '0;
                    end
                end
                REG_FEEDBACK_GAIN:
                begin
                    if ({1'b0, cfg_data} <= (CFG_DATA_W+1)'(UNITY))
                    begin
                        fb_gain_next = GAIN_W'(cfg_data);
                    end
                end
                REG_WET_MIX:
                begin
                    if ({1'b0, cfg_data} <= (CFG_DATA_W+1)'(UNITY))
                    begin
                        wet_next = GAIN_W'(cfg_data);
                    end
                end
                REG_INPUT_ROUTING:
                begin
                    in_route_next = in_route_t'(cfg_data[1:0]);
                end
                REG_OUTPUT_ROUTING:
                begin
                    out_route_next = out_route_t'(cfg_data[1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // clearing pass after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = ptr_inc(clr_addr_reg);
            if (clr_addr_reg == PTR_LAST)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // pipeline valid flags; forward when the next read hits the pending write
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        fwd_next = s1_advance && (rp_reg == s1_wp_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_gain_reg   <= '0;
            wet_reg       <= GAIN_W'(WET_RESET);
            in_route_reg  <= IN_STEREO;
            out_route_reg <= OUT_BOTH;
            wp_reg        <= WP_RESET;
            rp_reg        <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fb_gain_reg   <= fb_gain_next;
            wet_reg       <= wet_next;
            in_route_reg  <= in_route_next;
            out_route_reg <= out_route_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_left_reg  <= x_left;
            s1_x_right_reg <= x_right;
            s1_wp_reg      <= wp_reg;
            fwd_reg        <= fwd_next;
            fwd_left_reg   <= wr_left;
            fwd_right_reg  <= wr_right;
        end
    end

    // ring read, registered, on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_left_reg  <= ring_left[rp_reg];
            rd_right_reg <= ring_right[rp_reg];
        end
    end

    // delayed samples and gains
    assign d_left  = fwd_reg ? fwd_left_reg : rd_left_reg;
    assign d_right = fwd_reg ? fwd_right_reg : rd_right_reg;
    assign wet_s   = {1'b0, wet_reg};
    assign dry_s   = (GAIN_W+1)'(UNITY) - wet_s;
    assign fb_s    = {1'b0, fb_gain_reg};

    // wet/dry mix
    assign mix_left  = round_q15(ACC_W'(d_left) * ACC_W'(wet_s)
                                 + ACC_W'(s1_x_left_reg) * ACC_W'(dry_s));
    assign mix_right = round_q15(ACC_W'(d_right) * ACC_W'(wet_s)
                                 + ACC_W'(s1_x_right_reg) * ACC_W'(dry_s));
    assign y_left    = sat_io(mix_left);
    assign y_right   = sat_io(mix_right);

    // feedback into the rings
    assign fbp_left     = round_q15(ACC_W'(d_left) * ACC_W'(fb_s));
    assign fbp_right    = round_q15(ACC_W'(d_right) * ACC_W'(fb_s));
    assign wr_acc_left  = ACC_W'(s1_x_left_reg) + fbp_left;
    assign wr_acc_right = ACC_W'(s1_x_right_reg) + fbp_right;
    assign wr_left      = sat_ring(wr_acc_left);
    assign wr_right     = sat_ring(wr_acc_right);

    // output routing flags
    assign lv = (out_route_reg == OUT_LEFT_ONLY) || (out_route_reg == OUT_BOTH);
    assign rv = (out_route_reg == OUT_RIGHT_ONLY) || (out_route_reg == OUT_BOTH);

    // ring write port: clearing pass or first stage retiring
    assign ram_we       = clr_busy_reg || s1_advance;
    assign ram_addr     = clr_busy_reg ? clr_addr_reg : s1_wp_reg;
    assign ram_wd_left  = clr_busy_reg ? '0 : wr_left;
    assign ram_wd_right = clr_busy_reg ? '0 : wr_right;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ring_left[ram_addr]  <= ram_wd_left;
            ring_right[ram_addr] <= ram_wd_right;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_left_reg    <= lv ? y_left : '0;
            out_right_reg   <= rv ? y_right : '0;
            left_valid_reg  <= lv;
            right_valid_reg <= rv;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_left    = out_left_reg;
    assign out_right   = out_right_reg;
    assign left_valid  = left_valid_reg;
    assign right_valid = right_valid_reg;

    // no item is in flight while the rings are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("item in flight during ring clear");

    // a held first stage item is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("first stage item lost while output stalled");

    // an undriven channel carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (!left_valid || !right_valid)) |->
        ((left_valid || out_left == '0) && (right_valid || out_right == '0)))
        else $error("undriven channel carries a nonzero sample");

endmodule

`default_nettype wire
